@@ src/countdown_timer_controller_assert.svh @@
// ----------------------------------------------------------------------------
// countdown timer controller assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_CONTROLLER_ASSERT_SVH
`define COUNTDOWN_TIMER_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define CTC_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/ctc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctc_pkg
// types and codes shared by the countdown timer controller modules
// ----------------------------------------------------------------------------
package ctc_pkg;

   localparam int FUNC_W    = 3;
   localparam int DIGIT_W   = 4;
   localparam int MODE_W    = 2;
   localparam int SEC_W     = 13;
   localparam int BAR_W     = 10;
   localparam int LAMP_W    = 3;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_START    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PAUSE    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESET    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DIGIT    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_LOCK     = 3'd5;
   // spare codes, no effect
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_TICKS      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_TICKS      = 2'd2;

   localparam logic [CFG_W-1:0] TICKS_PER_SECOND_RST = 16'd1000;
   localparam logic [CFG_W-1:0] BLINK_TICKS_RST      = 16'd500;
   localparam logic [CFG_W-1:0] ALERT_TICKS_RST      = 16'd5000;

   localparam logic [LAMP_W-1:0] LAMP_OFF    = 3'b000;
   localparam logic [LAMP_W-1:0] LAMP_GREEN  = 3'b001;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'b010;
   localparam logic [LAMP_W-1:0] LAMP_RED    = 3'b100;

   localparam logic [1:0] STEP_GREEN = 2'd0;
   localparam logic [1:0] STEP_RED   = 2'd1;
   localparam logic [1:0] STEP_LAST  = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_SETTING  = 2'd0,
      MODE_RUNNING  = 2'd1,
      MODE_PAUSED   = 2'd2,
      MODE_FINISHED = 2'd3
   } mode_type;

   typedef struct packed {
      logic apply;
      logic div_init;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

@@ src/ctc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctc_ctrl
// sequencer: event apply, bar ratio steps and result register handoff
// ----------------------------------------------------------------------------
module ctc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ctc_pkg::cmd_type    cmd,
   input  ctc_pkg::status_type status
);
   import ctc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INIT   = 3'b010,
      ST_DIVIDE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.apply = 1'b1;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/ctc_datapath.sv @@
// ----------------------------------------------------------------------------
// ctc_datapath
// timer state, digit entry, finish phases, bar ratio unit and result register
// ----------------------------------------------------------------------------
module ctc_datapath #(
   parameter int BAR_SEGMENTS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ctc_pkg::FUNC_W-1:0]       req_func,
   input  logic [ctc_pkg::DIGIT_W-1:0]      req_digit,
   input  logic                             csr_write,
   input  logic [ctc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ctc_pkg::CFG_W-1:0]        csr_data,
   input  ctc_pkg::cmd_type                 cmd,
   output ctc_pkg::status_type              status,
   output logic [ctc_pkg::MODE_W-1:0]       rsp_mode,
   output logic [ctc_pkg::SEC_W-1:0]        rsp_remaining_sec,
   output logic [ctc_pkg::SEC_W-1:0]        rsp_total_sec,
   output logic [ctc_pkg::BAR_W-1:0]        rsp_bar_segments,
   output logic [ctc_pkg::LAMP_W-1:0]       rsp_status_lamps,
   output logic                             rsp_buzzer_on,
   output logic                             rsp_done_text_on,
   output logic                             rsp_lock_on,
   output logic                             rsp_bad_digit,
   output logic                             rsp_lock_refused
);
   import ctc_pkg::*;

   localparam int CNT_W = $clog2(BAR_SEGMENTS + 1);
   localparam int NUM_W = SEC_W + CNT_W;

   logic [CFG_W-1:0] tps_ff, tps_in, blink_ticks_ff, blink_ticks_in;
   logic [CFG_W-1:0] alert_ff, alert_in;

   mode_type         mode_ff, mode_in;
   logic             lock_ff, lock_in;
   logic [15:0]      tick_ff, tick_in;
   logic [SEC_W-1:0] rem_ff, rem_in, total_ff, total_in;
   logic [6:0]       min_ent_ff, min_ent_in;
   logic [5:0]       sec_ent_ff, sec_ent_in;
   logic [1:0]       min_dig_ff, min_dig_in, sec_dig_ff, sec_dig_in;
   logic [15:0]      since_ff, since_in, phase_ff, phase_in;
   logic             blink_ff, blink_in, buzz_ff, buzz_in;
   logic [1:0]       lamp_step_ff, lamp_step_in;
   logic             bad_ff, bad_in, refused_ff, refused_in;

   logic [16:0]      tick_inc, phase_inc;
   logic [6:0]       me;
   logic [5:0]       se;
   logic [1:0]       md, sd;
   logic [SEC_W-1:0] entry_sec;

   logic [NUM_W-1:0] num_ff, acc_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [BAR_W-1:0] bar_all, bar_ratio, bar_next;
   logic [LAMP_W-1:0] lamps_next;
   logic             buzz_next;

   assign tick_inc  = 17'(tick_ff) + 17'd1;
   assign phase_inc = 17'(phase_ff) + 17'd1;

   // configuration registers
   always_comb begin
      tps_in         = tps_ff;
      blink_ticks_in = blink_ticks_ff;
      alert_in       = alert_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: tps_in         = csr_data;
            CSR_BLINK_TICKS:      blink_ticks_in = csr_data;
            CSR_ALERT_TICKS:      alert_in       = csr_data;
            default: begin
            end
         endcase
      end
   end

   // digit entry after optional restart of a full entry
   always_comb begin
      if (min_dig_ff == 2'd2 && sec_dig_ff == 2'd2) begin
         me = '0;
         se = '0;
         md = '0;
         sd = '0;
      end else begin
         me = min_ent_ff;
         se = sec_ent_ff;
         md = min_dig_ff;
         sd = sec_dig_ff;
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      lock_in      = lock_ff;
      tick_in      = tick_ff;
      rem_in       = rem_ff;
      total_in     = total_ff;
      min_ent_in   = min_ent_ff;
      sec_ent_in   = sec_ent_ff;
      min_dig_in   = min_dig_ff;
      sec_dig_in   = sec_dig_ff;
      since_in     = since_ff;
      phase_in     = phase_ff;
      blink_in     = blink_ff;
      buzz_in      = buzz_ff;
      lamp_step_in = lamp_step_ff;
      bad_in       = bad_ff;
      refused_in   = refused_ff;
      entry_sec    = '0;
      if (cmd.apply) begin
         bad_in     = 1'b0;
         refused_in = 1'b0;
         case (req_func)
            FUNC_TICK: begin
               if (mode_ff == MODE_FINISHED) begin
                  if (since_ff != 16'hFFFF) begin
                     since_in = since_ff + 16'd1;
                  end
                  if (phase_inc >= 17'(blink_ticks_ff)) begin
                     phase_in     = '0;
                     blink_in     = !blink_ff;
                     buzz_in      = !buzz_ff;
                     lamp_step_in = (lamp_step_ff == STEP_LAST) ? STEP_GREEN
                                                                : lamp_step_ff + 2'd1;
                  end else begin
                     phase_in = phase_inc[15:0];
                  end
               end
               if (tick_inc >= 17'(tps_ff)) begin
                  tick_in = '0;
                  if (mode_ff == MODE_RUNNING && rem_ff != '0) begin
                     rem_in = rem_ff - 13'd1;
                     if (rem_ff == 13'd1) begin
                        mode_in      = MODE_FINISHED;
                        since_in     = '0;
                        phase_in     = '0;
                        blink_in     = 1'b0;
                        buzz_in      = 1'b0;
                        lamp_step_in = '0;
                     end
                  end
               end else begin
                  tick_in = tick_inc[15:0];
               end
            end
            FUNC_START: begin
               if (!lock_ff && rem_ff != '0) begin
                  mode_in = MODE_RUNNING;
               end
            end
            FUNC_PAUSE: begin
               if (!lock_ff) begin
                  if (mode_ff == MODE_RUNNING) begin
                     mode_in = MODE_PAUSED;
                  end else if (mode_ff == MODE_PAUSED) begin
                     mode_in = MODE_RUNNING;
                  end
               end
            end
            FUNC_RESET: begin
               if (!lock_ff) begin
                  rem_in       = '0;
                  total_in     = '0;
                  mode_in      = MODE_SETTING;
                  min_ent_in   = '0;
                  sec_ent_in   = '0;
                  min_dig_in   = '0;
                  sec_dig_in   = '0;
                  since_in     = '0;
                  phase_in     = '0;
                  blink_in     = 1'b0;
                  buzz_in      = 1'b0;
                  lamp_step_in = '0;
               end
            end
            FUNC_DIGIT: begin
               if (!lock_ff && req_digit <= 4'd9 &&
                   (mode_ff == MODE_SETTING || mode_ff == MODE_PAUSED)) begin
                  min_ent_in = me;
                  sec_ent_in = se;
                  min_dig_in = md;
                  sec_dig_in = sd;
                  if (md == 2'd0) begin
                     min_ent_in = 7'(7'(req_digit) * 7'd10);
                     min_dig_in = 2'd1;
                  end else if (md == 2'd1) begin
                     min_ent_in = me + 7'(req_digit);
                     min_dig_in = 2'd2;
                  end else if (sd == 2'd0) begin
                     if (req_digit > 4'd5) begin
                        bad_in = 1'b1;
                     end else begin
                        sec_ent_in = 6'(6'(req_digit) * 6'd10);
                        sec_dig_in = 2'd1;
                     end
                  end else if (sd == 2'd1) begin
                     sec_ent_in = se + 6'(req_digit);
                     sec_dig_in = 2'd2;
                  end
                  entry_sec = 13'(13'(min_ent_in) * 13'd60 + 13'(sec_ent_in));
                  rem_in    = entry_sec;
                  if (min_dig_in == 2'd2 && sec_dig_in == 2'd2) begin
                     total_in = entry_sec;
                  end
               end
            end
            FUNC_LOCK: begin
               if (mode_ff == MODE_SETTING || mode_ff == MODE_PAUSED) begin
                  lock_in = !lock_ff;
               end else begin
                  refused_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff         <= TICKS_PER_SECOND_RST;
         blink_ticks_ff <= BLINK_TICKS_RST;
         alert_ff       <= ALERT_TICKS_RST;
         mode_ff        <= MODE_SETTING;
         lock_ff        <= 1'b0;
         tick_ff        <= '0;
         rem_ff         <= '0;
         total_ff       <= '0;
         min_ent_ff     <= '0;
         sec_ent_ff     <= '0;
         min_dig_ff     <= '0;
         sec_dig_ff     <= '0;
         since_ff       <= '0;
         phase_ff       <= '0;
         blink_ff       <= 1'b0;
         buzz_ff        <= 1'b0;
         lamp_step_ff   <= '0;
         bad_ff         <= 1'b0;
         refused_ff     <= 1'b0;
      end else begin
         tps_ff         <= tps_in;
         blink_ticks_ff <= blink_ticks_in;
         alert_ff       <= alert_in;
         mode_ff        <= mode_in;
         lock_ff        <= lock_in;
         tick_ff        <= tick_in;
         rem_ff         <= rem_in;
         total_ff       <= total_in;
         min_ent_ff     <= min_ent_in;
         sec_ent_ff     <= sec_ent_in;
         min_dig_ff     <= min_dig_in;
         sec_dig_ff     <= sec_dig_in;
         since_ff       <= since_in;
         phase_ff       <= phase_in;
         blink_ff       <= blink_in;
         buzz_ff        <= buzz_in;
         lamp_step_ff   <= lamp_step_in;
         bad_ff         <= bad_in;
         refused_ff     <= refused_in;
      end
   end

   // bar ratio: count multiples of total that fit in remaining * segments
   assign status.div_done = (cnt_ff == CNT_W'(BAR_SEGMENTS)) || (num_ff < acc_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff <= NUM_W'(NUM_W'(rem_ff) * NUM_W'(BAR_SEGMENTS));
         acc_ff <= NUM_W'(total_ff);
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         acc_ff <= acc_ff + NUM_W'(total_ff);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   for (genvar g = 0; g < BAR_W; g++) begin : g_bar
      if (g < BAR_SEGMENTS) begin : g_lit
         assign bar_all[g]   = 1'b1;
         assign bar_ratio[g] = (cnt_ff > CNT_W'(g));
      end else begin : g_dark
         assign bar_all[g]   = 1'b0;
         assign bar_ratio[g] = 1'b0;
      end
   end

   always_comb begin
      bar_next   = '0;
      lamps_next = LAMP_OFF;
      buzz_next  = 1'b0;
      case (mode_ff)
         MODE_RUNNING: begin
            lamps_next = LAMP_GREEN;
            bar_next   = (total_ff == '0) ? '0 : bar_ratio;
         end
         MODE_PAUSED: begin
            lamps_next = LAMP_YELLOW;
            bar_next   = (total_ff == '0) ? '0 : bar_ratio;
         end
         MODE_FINISHED: begin
            bar_next = blink_ff ? bar_all : '0;
            if (since_ff < alert_ff) begin
               case (lamp_step_ff)
                  STEP_GREEN: lamps_next = LAMP_GREEN;
                  STEP_RED:   lamps_next = LAMP_RED;
                  default:    lamps_next = LAMP_YELLOW;
               endcase
               buzz_next = buzz_ff;
            end else begin
               lamps_next = LAMP_YELLOW;
               buzz_next  = 1'b1;
            end
         end
         default: begin
            bar_next = (total_ff == '0) ? '0 : bar_ratio;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_mode          <= mode_ff;
         rsp_remaining_sec <= rem_ff;
         rsp_total_sec     <= total_ff;
         rsp_bar_segments  <= bar_next;
         rsp_status_lamps  <= lamps_next;
         rsp_buzzer_on     <= buzz_next;
         rsp_done_text_on  <= (mode_ff == MODE_FINISHED) && blink_ff;
         rsp_lock_on       <= lock_ff;
         rsp_bad_digit     <= bad_ff;
         rsp_lock_refused  <= refused_ff;
      end
   end

endmodule

@@ src/countdown_timer_controller.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_controller
// event driven countdown timer with digit entry, child lock, bar and alarms
// handoff: req_stall holds new requests until the previous result is loaded,
//   which waits for the bar ratio unit, testing one segment multiple per
//   cycle, and for a free result register
// reset: synchronous; setting mode, times cleared, configuration registers at defaults
// ----------------------------------------------------------------------------
module countdown_timer_controller #(
   parameter int BAR_SEGMENTS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ctc_pkg::FUNC_W-1:0]    req_func,
   input  logic [ctc_pkg::DIGIT_W-1:0]   req_digit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ctc_pkg::MODE_W-1:0]    rsp_mode,
   output logic [ctc_pkg::SEC_W-1:0]     rsp_remaining_sec,
   output logic [ctc_pkg::SEC_W-1:0]     rsp_total_sec,
   output logic [ctc_pkg::BAR_W-1:0]     rsp_bar_segments,
   output logic [ctc_pkg::LAMP_W-1:0]    rsp_status_lamps,
   output logic                          rsp_buzzer_on,
   output logic                          rsp_done_text_on,
   output logic                          rsp_lock_on,
   output logic                          rsp_bad_digit,
   output logic                          rsp_lock_refused,
   input  logic                          csr_write,
   input  logic [ctc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctc_pkg::CFG_W-1:0]     csr_data
);
   import ctc_pkg::*;

   cmd_type    cmd;
   status_type status;

   ctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ctc_datapath #(
      .BAR_SEGMENTS (BAR_SEGMENTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_digit         (req_digit),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_mode          (rsp_mode),
      .rsp_remaining_sec (rsp_remaining_sec),
      .rsp_total_sec     (rsp_total_sec),
      .rsp_bar_segments  (rsp_bar_segments),
      .rsp_status_lamps  (rsp_status_lamps),
      .rsp_buzzer_on     (rsp_buzzer_on),
      .rsp_done_text_on  (rsp_done_text_on),
      .rsp_lock_on       (rsp_lock_on),
      .rsp_bad_digit     (rsp_bad_digit),
      .rsp_lock_refused  (rsp_lock_refused)
   );

endmodule

@@ src/ctc_checker.sv @@
// ----------------------------------------------------------------------------
// ctc_checker
// port level checks on result transactions of the countdown timer controller
// ----------------------------------------------------------------------------
`include "countdown_timer_controller_assert.svh"

module ctc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ctc_pkg::MODE_W-1:0]    rsp_mode,
   input logic [ctc_pkg::SEC_W-1:0]     rsp_remaining_sec,
   input logic [ctc_pkg::SEC_W-1:0]     rsp_total_sec,
   input logic [ctc_pkg::BAR_W-1:0]     rsp_bar_segments,
   input logic [ctc_pkg::LAMP_W-1:0]    rsp_status_lamps,
   input logic                          rsp_buzzer_on,
   input logic                          rsp_done_text_on
);
   import ctc_pkg::*;

   `CTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_remaining_sec) && $stable(rsp_mode), "stalled result changed")
   `CTC_ASSERT_IMPLIES(a_done_text, rsp_valid && rsp_mode != MODE_FINISHED, !rsp_done_text_on, "done text outside finished mode")
   `CTC_ASSERT_IMPLIES(a_setting_quiet, rsp_valid && rsp_mode == MODE_SETTING, rsp_status_lamps == LAMP_OFF && !rsp_buzzer_on, "lamps or buzzer active in setting mode")
   `CTC_ASSERT_IMPLIES(a_bar_empty, rsp_valid && rsp_mode != MODE_FINISHED && rsp_total_sec == '0, rsp_bar_segments == '0, "bar lit with zero total")

endmodule

bind countdown_timer_controller ctc_checker u_ctc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_mode          (rsp_mode),
   .rsp_remaining_sec (rsp_remaining_sec),
   .rsp_total_sec     (rsp_total_sec),
   .rsp_bar_segments  (rsp_bar_segments),
   .rsp_status_lamps  (rsp_status_lamps),
   .rsp_buzzer_on     (rsp_buzzer_on),
   .rsp_done_text_on  (rsp_done_text_on)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for countdown_timer_controller: events are driven
// with random gaps, every result is predicted by an internal timer model and
// compared field by field; directed cases first, then random timer sessions
// under several register settings, back-pressure and a long alarm soak
// ----------------------------------------------------------------------------
module tb;
   import ctc_pkg::*;

   typedef struct {
      mode_type           mode;
      logic [SEC_W-1:0]   remaining;
      logic [SEC_W-1:0]   total;
      logic [BAR_W-1:0]   bar;
      logic [LAMP_W-1:0]  lamps;
      logic               buzzer;
      logic               done_text;
      logic               lock;
      logic               bad_digit;
      logic               lock_refused;
   } panel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = FUNC_TICK;
   logic [DIGIT_W-1:0]   req_digit = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MODE_W-1:0]    rsp_mode;
   logic [SEC_W-1:0]     rsp_remaining_sec;
   logic [SEC_W-1:0]     rsp_total_sec;
   logic [BAR_W-1:0]     rsp_bar_segments;
   logic [LAMP_W-1:0]    rsp_status_lamps;
   logic                 rsp_buzzer_on;
   logic                 rsp_done_text_on;
   logic                 rsp_lock_on;
   logic                 rsp_bad_digit;
   logic                 rsp_lock_refused;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TICKS_PER_SECOND;
   logic [CFG_W-1:0]     csr_data = '0;

   panel_type expected_panels[$];
   int     fail_count = 0;
   int     sent_count = 0;
   bit     idling_on = 1'b1;
   int     hold_request = 0;
   int     hold_left = 0;

   // timer model state
   logic [CFG_W-1:0] cfg_ticks_per_second;
   logic [CFG_W-1:0] cfg_blink_ticks;
   logic [CFG_W-1:0] cfg_alert_ticks;
   mode_type         m_mode;
   logic             m_lock;
   logic [15:0]      m_ticks;
   logic [SEC_W-1:0] m_remaining;
   logic [SEC_W-1:0] m_total;
   logic [6:0]       m_minutes;
   logic [5:0]       m_seconds;
   logic [1:0]       m_min_digits;
   logic [1:0]       m_sec_digits;
   logic [15:0]      m_since_finish;
   logic [15:0]      m_phase;
   logic             m_blink;
   logic             m_buzz;
   logic [1:0]       m_lamp_step;

   countdown_timer_controller #(.BAR_SEGMENTS(BAR_W)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_digit         (req_digit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mode          (rsp_mode),
      .rsp_remaining_sec (rsp_remaining_sec),
      .rsp_total_sec     (rsp_total_sec),
      .rsp_bar_segments  (rsp_bar_segments),
      .rsp_status_lamps  (rsp_status_lamps),
      .rsp_buzzer_on     (rsp_buzzer_on),
      .rsp_done_text_on  (rsp_done_text_on),
      .rsp_lock_on       (rsp_lock_on),
      .rsp_bad_digit     (rsp_bad_digit),
      .rsp_lock_refused  (rsp_lock_refused),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void clear_entry();
      m_minutes = '0;
      m_seconds = '0;
      m_min_digits = '0;
      m_sec_digits = '0;
   endfunction

   function automatic void clear_phases();
      m_since_finish = '0;
      m_phase = '0;
      m_blink = 1'b0;
      m_buzz = 1'b0;
      m_lamp_step = STEP_GREEN;
   endfunction

   function automatic void reset_timer_model();
      cfg_ticks_per_second = TICKS_PER_SECOND_RST;
      cfg_blink_ticks = BLINK_TICKS_RST;
      cfg_alert_ticks = ALERT_TICKS_RST;
      m_mode = MODE_SETTING;
      m_lock = 1'b0;
      m_ticks = '0;
      m_remaining = '0;
      m_total = '0;
      clear_entry();
      clear_phases();
   endfunction

   function automatic void count_tick();
      int unsigned next;
      if (m_mode == MODE_FINISHED) begin
         if (m_since_finish != 16'hFFFF) m_since_finish = m_since_finish + 1'b1;
         next = int'(m_phase) + 1;
         if (next >= int'(cfg_blink_ticks)) begin
            next = 0;
            m_blink = ~m_blink;
            m_buzz = ~m_buzz;
            m_lamp_step = (m_lamp_step == STEP_LAST) ? STEP_GREEN : m_lamp_step + 1'b1;
         end
         m_phase = next[15:0];
      end
      next = int'(m_ticks) + 1;
      if (next >= int'(cfg_ticks_per_second)) begin
         next = 0;
         if (m_mode == MODE_RUNNING && m_remaining != 0) begin
            m_remaining = m_remaining - 1'b1;
            if (m_remaining == 0) begin
               m_mode = MODE_FINISHED;
               clear_phases();
            end
         end
      end
      m_ticks = next[15:0];
   endfunction

   // returns 1 when a seconds-tens digit above five is rejected
   function automatic logic enter_digit(input logic [DIGIT_W-1:0] d);
      logic        bad;
      int unsigned secs;
      bad = 1'b0;
      if (d > 9 || !(m_mode == MODE_SETTING || m_mode == MODE_PAUSED)) return 1'b0;
      if (m_min_digits == 2 && m_sec_digits == 2) clear_entry();
      if (m_min_digits == 0) begin
         m_minutes = 7'(int'(d) * 10);
         m_min_digits = 2'd1;
      end else if (m_min_digits == 1) begin
         m_minutes = 7'(int'(m_minutes) + int'(d));
         m_min_digits = 2'd2;
      end else if (m_sec_digits == 0) begin
         if (d > 5) begin
            bad = 1'b1;
         end else begin
            m_seconds = 6'(int'(d) * 10);
            m_sec_digits = 2'd1;
         end
      end else if (m_sec_digits == 1) begin
         m_seconds = 6'(int'(m_seconds) + int'(d));
         m_sec_digits = 2'd2;
      end
      secs = int'(m_minutes) * 60 + int'(m_seconds);
      m_remaining = secs[SEC_W-1:0];
      if (m_min_digits == 2 && m_sec_digits == 2) m_total = m_remaining;
      return bad;
   endfunction

   function automatic panel_type advance_timer(input logic [FUNC_W-1:0] f,
                                               input logic [DIGIT_W-1:0] d);
      panel_type   p;
      int unsigned segs;
      p.bad_digit = 1'b0;
      p.lock_refused = 1'b0;
      case (f)
         FUNC_TICK: count_tick();
         FUNC_START: if (!m_lock && m_remaining != 0) m_mode = MODE_RUNNING;
         FUNC_PAUSE: begin
            if (!m_lock) begin
               if (m_mode == MODE_RUNNING) m_mode = MODE_PAUSED;
               else if (m_mode == MODE_PAUSED) m_mode = MODE_RUNNING;
            end
         end
         FUNC_RESET: begin
            if (!m_lock) begin
               m_remaining = '0;
               m_total = '0;
               m_mode = MODE_SETTING;
               clear_entry();
               clear_phases();
            end
         end
         FUNC_DIGIT: if (!m_lock) p.bad_digit = enter_digit(d);
         FUNC_LOCK: begin
            if (m_mode == MODE_SETTING || m_mode == MODE_PAUSED) m_lock = ~m_lock;
            else p.lock_refused = 1'b1;
         end
         default: ;
      endcase

      p.lamps = LAMP_OFF;
      p.buzzer = 1'b0;
      p.done_text = 1'b0;
      case (m_mode)
         MODE_RUNNING: p.lamps = LAMP_GREEN;
         MODE_PAUSED:  p.lamps = LAMP_YELLOW;
         MODE_FINISHED: begin
            p.done_text = m_blink;
            if (m_since_finish < cfg_alert_ticks) begin
               case (m_lamp_step)
                  STEP_GREEN: p.lamps = LAMP_GREEN;
                  STEP_RED:   p.lamps = LAMP_RED;
                  default:    p.lamps = LAMP_YELLOW;
               endcase
               p.buzzer = m_buzz;
            end else begin
               p.lamps = LAMP_YELLOW;
               p.buzzer = 1'b1;
            end
         end
         default: ;
      endcase

      if (m_mode == MODE_FINISHED) begin
         p.bar = {BAR_W{m_blink}};
      end else if (m_total == 0) begin
         p.bar = '0;
      end else begin
         segs = (int'(m_remaining) * BAR_W) / int'(m_total);
         p.bar = (segs >= BAR_W) ? {BAR_W{1'b1}} : BAR_W'((1 << segs) - 1);
      end
      p.mode = m_mode;
      p.remaining = m_remaining;
      p.total = m_total;
      p.lock = m_lock;
      return p;
   endfunction

   task automatic send_event(input logic [FUNC_W-1:0] f, input logic [DIGIT_W-1:0] d);
      bit accepted;
      @(negedge clock);
      while (idling_on && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_digit <= d;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = !req_stall;
      end
      expected_panels.push_back(advance_timer(f, d));
      sent_count++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_panels.size() != 0) @(posedge clock);
      repeat (BAR_W + 4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TICKS_PER_SECOND: cfg_ticks_per_second = value;
         CSR_BLINK_TICKS:      cfg_blink_ticks = value;
         CSR_ALERT_TICKS:      cfg_alert_ticks = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [CFG_W-1:0] tps, input logic [CFG_W-1:0] blink,
                             input logic [CFG_W-1:0] alert);
      write_register(CSR_TICKS_PER_SECOND, tps);
      write_register(CSR_BLINK_TICKS, blink);
      write_register(CSR_ALERT_TICKS, alert);
   endtask

   // locked implies setting or paused, so one toggle always releases it
   task automatic release_lock();
      if (m_lock) send_event(FUNC_LOCK, 4'($urandom_range(0, 15)));
   endtask

   function automatic logic [DIGIT_W-1:0] entry_digit(input int slot);
      case (slot)
         0: return ($urandom_range(0, 11) == 0) ? 4'($urandom_range(0, 9)) : 4'd0;
         1: return ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 9)) : 4'd0;
         2: return ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 5))
                                                : 4'($urandom_range(0, 2));
         default: return 4'($urandom_range(0, 9));
      endcase
   endfunction

   // one countdown: release lock, usually clear, enter MMSS, start, then mostly ticks with noise
   task automatic run_session();
      int n;
      int r;
      release_lock();
      if ($urandom_range(0, 9) != 0) send_event(FUNC_RESET, 4'($urandom_range(0, 15)));
      for (int slot = 0; slot < 4; slot++) begin
         if ($urandom_range(0, 19) == 0) send_event(FUNC_DIGIT, 4'($urandom_range(10, 15)));
         if (slot == 2 && $urandom_range(0, 7) == 0)
            send_event(FUNC_DIGIT, 4'($urandom_range(6, 9)));
         send_event(FUNC_DIGIT, entry_digit(slot));
      end
      send_event(FUNC_START, 4'($urandom_range(0, 15)));
      n = $urandom_range(10, 80);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 78)      send_event(FUNC_TICK, 4'($urandom_range(0, 15)));
         else if (r < 82) send_event(FUNC_PAUSE, 4'($urandom_range(0, 15)));
         else if (r < 85) send_event(FUNC_START, 4'($urandom_range(0, 15)));
         else if (r < 88) send_event(FUNC_LOCK, 4'($urandom_range(0, 15)));
         else if (r < 94) send_event(FUNC_DIGIT, 4'($urandom_range(0, 15)));
         else if (r < 96) send_event(FUNC_RESET, 4'($urandom_range(0, 15)));
         else             send_event(($urandom_range(0, 1) == 0) ? FUNC_SPARE_LO
                                                                  : FUNC_SPARE_HI,
                                     4'($urandom_range(0, 15)));
      end
   endtask

   // entry rules and child lock under the reset timing
   task automatic test_entry_and_lock();
      send_event(FUNC_SPARE_HI, 4'd0);
      send_event(FUNC_PAUSE, 4'd0);
      send_event(FUNC_START, 4'd0);
      send_event(FUNC_DIGIT, 4'd15);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd9);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd2);
      send_event(FUNC_LOCK, 4'd0);
      send_event(FUNC_START, 4'd0);
      send_event(FUNC_TICK, 4'd0);
      wait_for_results();
      send_event(FUNC_LOCK, 4'd0);
      send_event(FUNC_START, 4'd0);
      send_event(FUNC_LOCK, 4'd0);
      send_event(FUNC_PAUSE, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_PAUSE, 4'd0);
      send_event(FUNC_TICK, 4'd0);
      wait_for_results();
   endtask

   // largest entry, then a short countdown through finish into steady alarm
   task automatic test_finish_and_alarm();
      set_timing(16'd0, 16'd0, 16'd2);
      send_event(FUNC_RESET, 4'd0);
      send_event(FUNC_DIGIT, 4'd9);
      send_event(FUNC_DIGIT, 4'd9);
      send_event(FUNC_DIGIT, 4'd5);
      send_event(FUNC_DIGIT, 4'd9);
      send_event(FUNC_RESET, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd2);
      send_event(FUNC_START, 4'd0);
      repeat (5) send_event(FUNC_TICK, 4'd0);
      send_event(FUNC_LOCK, 4'd0);
      send_event(FUNC_PAUSE, 4'd0);
      send_event(FUNC_START, 4'd0);
      send_event(FUNC_RESET, 4'd0);
      wait_for_results();
   endtask

   // result side held off while events keep coming
   task automatic test_backpressure();
      set_timing(16'd1, 16'd2, 16'd10);
      hold_request = 300;
      run_session();
      wait_for_results();
   endtask

   task automatic test_random_sessions();
      int target;
      int phase;
      int phase_end;
      target = sent_count + 850;
      phase = 0;
      while (sent_count < target) begin
         case (phase)
            0: set_timing(16'd0, 16'd0, 16'd0);
            1: set_timing(16'd1, 16'hFFFF, 16'hFFFF);
            default: set_timing(CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 5)),
                                CFG_W'($urandom_range(0, 40)));
         endcase
         idling_on = (phase != 2);
         phase_end = sent_count + 200;
         while (sent_count < phase_end && sent_count < target) run_session();
         wait_for_results();
         phase++;
      end
      idling_on = 1'b1;
   endtask

   // finished stretch past the alert window with the widest blink phase
   task automatic test_alarm_soak();
      set_timing(16'd1, 16'hFFFF, 16'd100);
      release_lock();
      send_event(FUNC_RESET, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd0);
      send_event(FUNC_DIGIT, 4'd1);
      send_event(FUNC_START, 4'd0);
      send_event(FUNC_TICK, 4'd0);
      wait_for_results();
      write_register(CSR_TICKS_PER_SECOND, 16'hFFFF);
      idling_on = 1'b0;
      repeat (150) send_event(FUNC_TICK, 4'($urandom_range(0, 15)));
      idling_on = 1'b1;
      wait_for_results();
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= idling_on && ($urandom_range(0, 99) < 8);
      end
   end

   always @(posedge clock) begin : check_results
      panel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_panels.size() == 0) begin
            $error("unexpected transaction, mode %0d", rsp_mode);
            fail_count++;
         end else begin
            want = expected_panels.pop_front();
            compare_field("mode", want.mode, rsp_mode);
            compare_field("remaining_sec", want.remaining, rsp_remaining_sec);
            compare_field("total_sec", want.total, rsp_total_sec);
            compare_field("bar_segments", want.bar, rsp_bar_segments);
            compare_field("status_lamps", want.lamps, rsp_status_lamps);
            compare_field("buzzer_on", want.buzzer, rsp_buzzer_on);
            compare_field("done_text_on", want.done_text, rsp_done_text_on);
            compare_field("lock_on", want.lock, rsp_lock_on);
            compare_field("bad_digit", want.bad_digit, rsp_bad_digit);
            compare_field("lock_refused", want.lock_refused, rsp_lock_refused);
         end
      end
   end

   initial begin
      reset_timer_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_entry_and_lock();
      test_finish_and_alarm();
      test_backpressure();
      test_random_sessions();
      test_alarm_soak();
      if (expected_panels.size() != 0) begin
         $error("transactions missing: %0d", expected_panels.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
